[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the NTC temperature converter; the top level includes them.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLKD(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_BLK(lbl, prop, msg) \
	`ASSERT_CLKD(lbl, clk, arst_n, prop, msg)

`endif

[hw/rtl/ntc_pkg.sv]
// Package for the NTC ADC-to-temperature converter: sizes, calibration table,
// fixed-point constants and the controller/datapath command and status types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ntc_pkg;

	localparam int ADC_W          = 12;
	localparam int TEMP_W         = 16;
	localparam int STORED_ENTRIES = 71;
	localparam int TABLE_ENTRIES  = 71;
	localparam int FRAC_BITS      = 8;
	localparam int TEMP_MIN       = -30;
	localparam int TEMP_MAX       = 110;
	localparam int STEP_LOG2      = 1;          // step of 2 degrees
	localparam int TEMP_STEP      = 1 << STEP_LOG2;

	// Entries actually searched
	localparam int SEARCH_COUNT = (TABLE_ENTRIES > STORED_ENTRIES) ?
		STORED_ENTRIES : TABLE_ENTRIES;
	localparam int IDX_W     = $clog2(SEARCH_COUNT + 1);
	localparam int TBL_IDX_W = $clog2(STORED_ENTRIES);

	// Quotient of STEP * num * 2^FRAC_BITS / span with num <= span: one integer
	// bit taken at load, then one fraction bit per divide step
	localparam int DIV_STEPS = STEP_LOG2 + FRAC_BITS;
	localparam int QUO_W     = DIV_STEPS + 1;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	// Integer degrees stay within 11 signed bits for up to 256 entries
	localparam int DEG_W = 11;
	localparam int FIX_W = (DEG_W + FRAC_BITS > TEMP_W) ? DEG_W + FRAC_BITS : TEMP_W;

	localparam logic [TEMP_W-1:0] MIN_FIX = TEMP_W'(TEMP_MIN * (1 << FRAC_BITS));
	localparam logic [TEMP_W-1:0] MAX_FIX = TEMP_W'(TEMP_MAX * (1 << FRAC_BITS));

	// ADC reading at each 2-degree point from -30 up, falling
	localparam logic [ADC_W-1:0] NTC_POINTS [STORED_ENTRIES] = '{
		12'd4005, 12'd3989, 12'd3970, 12'd3949, 12'd3925, 12'd3897, 12'd3866, 12'd3831,
		12'd3791, 12'd3747, 12'd3698, 12'd3643, 12'd3583, 12'd3518, 12'd3446, 12'd3369,
		12'd3286, 12'd3198, 12'd3104, 12'd3005, 12'd2902, 12'd2794, 12'd2683, 12'd2570,
		12'd2455, 12'd2338, 12'd2222, 12'd2105, 12'd1990, 12'd1877, 12'd1766, 12'd1658,
		12'd1554, 12'd1454, 12'd1358, 12'd1267, 12'd1180, 12'd1098, 12'd1020, 12'd947,
		12'd879,  12'd815,  12'd755,  12'd700,  12'd648,  12'd600,  12'd556,  12'd515,
		12'd477,  12'd441,  12'd409,  12'd379,  12'd351,  12'd325,  12'd302,  12'd280,
		12'd260,  12'd241,  12'd224,  12'd208,  12'd194,  12'd180,  12'd168,  12'd157,
		12'd146,  12'd136,  12'd127,  12'd119,  12'd111,  12'd104,  12'd97
	};

	function automatic logic [ADC_W-1:0] ntc_point(input logic [TBL_IDX_W-1:0] idx);
		logic [ADC_W-1:0] val;
		val = '0;
		if (int'(idx) < STORED_ENTRIES) begin
			val = NTC_POINTS[idx];
		end
		return val;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LOAD_PREV,
		ST_LOAD_CUR,
		ST_DIVIDE,
		ST_FINISH
	} ntc_state_t;

	typedef struct packed {
		logic load;
		logic search_step;
		logic load_prev;
		logic load_cur;
		logic div_step;
		logic finish;
	} ntc_cmd_t;

	typedef struct packed {
		logic search_done;
		logic edge_hit;
		logic div_last;
	} ntc_sts_t;

endpackage

`default_nettype wire

[hw/rtl/ntc_adc_to_temperature.sv]
// Top level of the NTC ADC-to-temperature converter: controller plus datapath.
// Depends on ntc_pkg, ntc_ctrl, ntc_dpath and assert_macros.svh.
//
// Usage: drive adc_value and raise start while busy is low; the request is
// taken at that clock edge. busy stays high while the conversion runs. The
// result appears on temperature_q8 (signed, 8 fraction bits) for exactly one
// cycle with done high; the receiver must take it then, it cannot stall.
// Sequence after the accepting edge: edge readings (at/above first entry or
// below the last) go from the search straight to the result write; other
// readings go through the search, 2 operand loads, 9 divide steps and the
// result write, and the result write then raises done. The binary search
// runs over the 71-entry table. One request is in flight at a time; a new one may be
// taken in the cycle done is high. The serial restoring divider, one
// quotient bit per cycle, and the one-entry-per-cycle table read set the rate.
// Reset clears the controller to idle and drops done; no table or memory
// needs initialization.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ntc_adc_to_temperature import ntc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ADC_W-1:0]  adc_value,
	output logic                   done,
	output logic [TEMP_W-1:0]      temperature_q8
);

	ntc_cmd_t cmd;
	ntc_sts_t sts;

	ntc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ntc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.adc_value      (adc_value),
		.sts            (sts),
		.done           (done),
		.temperature_q8 (temperature_q8)
	);

	`ASSERT_BLK(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
	`ASSERT_BLK(a_done_idle, done |-> !busy, "result strobe while still busy")
	`ASSERT_BLK(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
	`ASSERT_BLK(a_finish_done, cmd.finish |=> done, "finish step did not produce a result")

endmodule

`default_nettype wire

[hw/rtl/ntc_ctrl.sv]
// Controller of the NTC converter: sequences search, operand load, divide
// and result write. Depends on ntc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntc_ctrl import ntc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire ntc_sts_t sts,
	output ntc_cmd_t      cmd,
	output logic          busy
);

	ntc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (sts.search_done) begin
					state_d = sts.edge_hit ? ST_FINISH : ST_LOAD_PREV;
				end
			end
			ST_LOAD_PREV: state_d = ST_LOAD_CUR;
			ST_LOAD_CUR:  state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (sts.div_last) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SEARCH:    cmd.search_step = !sts.search_done;
			ST_LOAD_PREV: cmd.load_prev   = 1'b1;
			ST_LOAD_CUR:  cmd.load_cur    = 1'b1;
			ST_DIVIDE:    cmd.div_step    = 1'b1;
			ST_FINISH:    cmd.finish      = 1'b1;
			default:      busy            = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/ntc_dpath.sv]
// Datapath of the NTC converter: binary search over the table, restoring
// divider for the interpolation fraction, result register. Depends on ntc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntc_dpath import ntc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ntc_cmd_t          cmd,
	input  wire logic [ADC_W-1:0]  adc_value,
	output ntc_sts_t               sts,
	output logic                   done,
	output logic [TEMP_W-1:0]      temperature_q8
);

	logic [ADC_W-1:0]  adc_q;
	logic [IDX_W-1:0]  lo_q, hi_q;
	logic [ADC_W-1:0]  prev_q, span_q, rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TEMP_W-1:0] result_q;
	logic              done_q;

	logic [IDX_W-1:0]  mid, lo_m1, rd_idx;
	logic [ADC_W-1:0]  point, num, cur_span;
	logic              int_bit;
	logic [ADC_W:0]    rem_sh;
	logic              fits;
	logic              lo_edge, hi_edge;
	logic [FIX_W-1:0]  deg_fix, sum_fix;

	// mid stays at most SEARCH_COUNT; the sum is one bit wider, so it never overflows in value
	assign mid   = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign lo_m1 = lo_q - 1'b1;

	always_comb begin
		priority if (cmd.load_prev) rd_idx = lo_m1;
		else if (cmd.load_cur)      rd_idx = lo_q;
		else                        rd_idx = mid;
	end

	assign point = ntc_point(TBL_IDX_W'(rd_idx));
	assign num   = (prev_q > adc_q) ? prev_q - adc_q : '0;

	// A reading equal to the lower entry gives a full step: take that bit up front
	assign cur_span = (prev_q > point) ? prev_q - point : '0;
	assign int_bit  = num >= cur_span;

	assign rem_sh = {rem_q, 1'b0};
	assign fits   = rem_sh >= {1'b0, span_q};

	assign lo_edge = lo_q == '0;
	assign hi_edge = lo_q == IDX_W'(SEARCH_COUNT);

	assign sts.search_done = lo_q == hi_q;
	assign sts.edge_hit    = lo_edge || hi_edge;
	assign sts.div_last    = cnt_q == CNT_W'(1);

	// Base temperature of the lower neighbor, in fixed point
	assign deg_fix = (FIX_W'(TEMP_MIN) + (FIX_W'(lo_m1) << STEP_LOG2)) << FRAC_BITS;
	assign sum_fix = deg_fix + ((span_q == '0) ? '0 : FIX_W'(quo_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			adc_q <= adc_value;
			lo_q  <= '0;
			hi_q  <= IDX_W'(SEARCH_COUNT);
		end
		if (cmd.search_step) begin
			if (point <= adc_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + 1'b1;
			end
		end
		if (cmd.load_prev) begin
			prev_q <= point;
		end
		if (cmd.load_cur) begin
			span_q <= cur_span;
			rem_q  <= int_bit ? num - cur_span : num;
			quo_q  <= QUO_W'(int_bit);
			cnt_q  <= CNT_W'(DIV_STEPS);
		end
		if (cmd.div_step) begin
			rem_q <= fits ? ADC_W'(rem_sh - {1'b0, span_q}) : ADC_W'(rem_sh);
			quo_q <= QUO_W'({quo_q, fits});
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.finish) begin
			priority if (lo_edge) result_q <= MIN_FIX;
			else if (hi_edge)     result_q <= MAX_FIX;
			else                  result_q <= sum_fix[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done           = done_q;
	assign temperature_q8 = result_q;

endmodule

`default_nettype wire
